@@ rtl/core/bar_pkg.sv @@
// ----------------------------------------------------------------------------
// bar_pkg
// Types, codes and bit positions for the bit-addressed UART register block.
// ----------------------------------------------------------------------------
package bar_pkg;

	// command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_POLL  = 2'd2;

	// write-side bit numbers
	localparam logic [4:0] B_RESET  = 5'd31;
	localparam logic [4:0] B_XBIENB = 5'd19;
	localparam logic [4:0] B_RIENB  = 5'd18;
	localparam logic [4:0] B_BRKON  = 5'd17;
	localparam logic [4:0] B_LDCTRL = 5'd14;
	localparam logic [4:0] B_LDIR   = 5'd13;
	localparam logic [4:0] B_LRDR   = 5'd12;
	localparam logic [4:0] B_LXDR   = 5'd11;

	// data register loading
	localparam logic [4:0] REG_LAST  = 5'd11;
	localparam logic [4:0] CTRL_LAST = 5'd7;
	localparam logic [4:0] RATE_LAST = 5'd10;
	localparam logic [4:0] SEND_BIT  = 5'd7;

	localparam int REG_W  = 12;
	localparam int CHAR_W = 8;

	typedef struct packed {
		logic [1:0]        command;
		logic [4:0]        bit_addr;
		logic              bit_value;
		logic              rx_ready;
		logic [CHAR_W-1:0] rx_char;
		logic              tx_ready;
	} item_t;

	typedef struct packed {
		logic              read_bit;
		logic              tx_valid;
		logic [CHAR_W-1:0] tx_char;
		logic              rx_taken;
		logic              irq;
	} result_t;

	// write bits that carry meaning
	typedef struct packed {
		logic xbienb;
		logic rienb;
		logic brkon;
		logic ldctrl;
		logic ldir;
		logic lrdr;
		logic lxdr;
	} wbits_t;

	localparam wbits_t WB_RESET = '{xbienb: 1'b0, rienb: 1'b0, brkon: 1'b0,
		ldctrl: 1'b1, ldir: 1'b1, lrdr: 1'b1, lxdr: 1'b1};

	// status bits that can be nonzero
	typedef struct packed {
		logic              intr;
		logic              flag;
		logic              xbre;
		logic              rbrl;
		logic              xbint;
		logic              rbint;
		logic [CHAR_W-1:0] rx_data;
	} stat_t;

	typedef struct packed {
		wbits_t           wb;
		stat_t            st;
		logic [REG_W-1:0] control;
		logic [REG_W-1:0] interval;
		logic [REG_W-1:0] rx_rate;
		logic [REG_W-1:0] tx_rate;
		logic [REG_W-1:0] tx_data;
	} state_t;

	localparam state_t STATE_RESET = '{wb: WB_RESET, st: '0, control: '0,
		interval: '0, rx_rate: '0, tx_rate: '0, tx_data: '0};

endpackage

@@ rtl/core/bar_ifs.sv @@
// ----------------------------------------------------------------------------
// bar_ifs
// Valid/ready channels for requests and results of the register block.
// ----------------------------------------------------------------------------
interface bar_req_if;
	logic            valid;
	logic            ready;
	bar_pkg::item_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bar_rsp_if;
	logic             valid;
	logic             ready;
	bar_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/bit_addressed_uart_regs.sv @@
// ----------------------------------------------------------------------------
// bit_addressed_uart_regs
// Register side of a UART reached one bit at a time over a request channel.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                        | per request
//  --------+-----+------------------------------------------------+------------
//  req     | in  | command, bit_addr, bit_value, rx_ready,        | one
//          |     | rx_char, tx_ready                              |
//  rsp     | out | read_bit, tx_valid, tx_char, rx_taken, irq     | one
//
//  One request per cycle sustained while results drain; each gives exactly
//  one result, passed from the request register into the result register.
//  The whole state update is one pass of bit logic between the request
//  register and the result register, so state is current for the next one.
//  Reset (arst_n low) restores the load flags and clears status and the data
//  registers; both channel stages come up empty.
//  A stalled result holds; the request stage keeps taking requests as long as
//  the result register is free or being drained the same cycle.
//
module bit_addressed_uart_regs (
	input  logic             clk,
	input  logic             arst_n,
	bar_req_if.sink          req,
	bar_rsp_if.source        rsp
);
	import bar_pkg::*;

	// request stage
	logic    req_vld_s1;
	item_t   req_s1;

	// architectural state and result register
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t rsp_q;
	logic    rsp_vld_q;

	logic    advance;

	// the request in stage 1 moves on when the result register can take it
	assign advance   = req_vld_s1 && (!rsp_vld_q || rsp.ready);
	assign req.ready = !req_vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1 <= 1'b0;
		end else if (req.ready) begin
			req_vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) req_s1 <= req.data;
	end

	bar_step u_step (
		.cur  (state_q),
		.item (req_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// state only changes as a request is retired into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (advance) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) rsp_q <= res_nxt;
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_q;

endmodule

@@ rtl/core/bar_step.sv @@
// ----------------------------------------------------------------------------
// bar_step
// Next state and result for one request: bit write, bit read or line poll.
// ----------------------------------------------------------------------------
module bar_step (
	input  bar_pkg::state_t  cur,
	input  bar_pkg::item_t   item,
	output bar_pkg::state_t  nxt,
	output bar_pkg::result_t res
);
	import bar_pkg::*;

	logic [3:0]  ra;
	logic        do_rc;
	logic [31:0] sword;

	// status word as the bus sees it
	assign sword = {cur.st.intr, cur.st.flag, 7'd0, cur.st.xbre, cur.st.rbrl, 3'd0,
		cur.st.xbint, cur.st.rbint, 8'd0, cur.st.rx_data};

	always_comb begin
		nxt   = cur;
		res   = '0;
		do_rc = 1'b0;
		ra    = item.bit_addr[3:0];
		case (item.command)
			CMD_WRITE: begin
				do_rc = 1'b1;
				case (item.bit_addr)
					B_XBIENB: nxt.wb.xbienb = item.bit_value;
					B_RIENB: begin
						nxt.wb.rienb = item.bit_value;
						nxt.st.rbrl  = 1'b0;
					end
					B_BRKON:  nxt.wb.brkon  = item.bit_value;
					B_LDCTRL: nxt.wb.ldctrl = item.bit_value;
					B_LDIR:   nxt.wb.ldir   = item.bit_value;
					B_LRDR:   nxt.wb.lrdr   = item.bit_value;
					B_LXDR:   nxt.wb.lxdr   = item.bit_value;
					B_RESET: begin
						nxt.wb = WB_RESET;
						nxt.st = '0;
					end
					default: ;
				endcase
				if (item.bit_addr <= REG_LAST) begin
					if (nxt.wb.ldctrl) begin
						nxt.control[ra] = item.bit_value;
						if (item.bit_addr == CTRL_LAST) nxt.wb.ldctrl = 1'b0;
					end else if (nxt.wb.ldir) begin
						nxt.interval[ra] = item.bit_value;
						if (item.bit_addr == CTRL_LAST) nxt.wb.ldir = 1'b0;
					end else if (nxt.wb.lrdr) begin
						nxt.rx_rate[ra] = item.bit_value;
						if (nxt.wb.lxdr) nxt.tx_rate[ra] = item.bit_value;
						if (item.bit_addr == RATE_LAST) nxt.wb.lrdr = 1'b0;
					end else if (nxt.wb.lxdr) begin
						nxt.tx_rate[ra] = item.bit_value;
						if (item.bit_addr == RATE_LAST) nxt.wb.lxdr = 1'b0;
					end else begin
						nxt.tx_data[ra] = item.bit_value;
						if (item.bit_addr == SEND_BIT) begin
							res.tx_valid = 1'b1;
							res.tx_char  = nxt.tx_data[CHAR_W-1:0];
							nxt.st.xbre  = 1'b0;
						end
					end
				end
			end
			CMD_READ: res.read_bit = sword[item.bit_addr];
			CMD_POLL: do_rc = 1'b1;
			default: ;
		endcase

		if (do_rc) begin
			if (item.rx_ready && !nxt.st.rbrl) begin
				nxt.st.rbrl    = 1'b1;
				nxt.st.rx_data = item.rx_char;
				res.rx_taken   = 1'b1;
			end
			if (item.tx_ready) nxt.st.xbre = 1'b1;
			nxt.st.xbint = nxt.st.xbre & nxt.wb.xbienb;
			nxt.st.rbint = nxt.st.rbrl & nxt.wb.rienb;
			nxt.st.flag  = nxt.wb.ldctrl | nxt.wb.ldir | nxt.wb.lrdr | nxt.wb.lxdr |
				nxt.wb.brkon;
			nxt.st.intr  = nxt.st.xbint | nxt.st.rbint;
		end
		res.irq = nxt.st.intr;
	end

endmodule

@@ rtl/core/bar_checker.sv @@
// ----------------------------------------------------------------------------
// bar_checker
// Port-level checks on the register block, bound to the top level.
// ----------------------------------------------------------------------------
module bar_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input bar_pkg::result_t  rsp_data
);
	import bar_pkg::*;

	// a result waiting on the sink keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// a result with its read bit set never sends or latches a character
	a_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.read_bit |-> !rsp_data.tx_valid && !rsp_data.rx_taken)
		else $error("read result with side effects");

	// no character is shown unless one is sent
	a_tx_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.tx_valid |-> rsp_data.tx_char == '0)
		else $error("tx_char set without tx_valid");

	// an idle request side with an empty request stage gives no fresh result
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready && !req_valid && !rsp_valid ##1 !req_valid && !rsp_valid |=> !rsp_valid)
		else $error("result without a request");

endmodule

bind bit_addressed_uart_regs bar_checker u_bar_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

@@ sim/tb_bit_addressed_uart_regs.sv @@
// ----------------------------------------------------------------------------
// tb_bit_addressed_uart_regs
// Drives bit-level register requests and serial-line events into the UART
// register block. A local copy of the control word, the status word and the
// transmit data register predicts each reply, and the replies are checked
// in order. Both channels stall at random; the result side also holds off
// for long stretches so that the block backs up.
// ----------------------------------------------------------------------------
module tb_bit_addressed_uart_regs;
	timeunit 1ns;
	timeprecision 1ps;

	import bar_pkg::*;

	// status word bit positions
	localparam logic [4:0] S_INT   = 5'd31;
	localparam logic [4:0] S_FLAG  = 5'd30;
	localparam logic [4:0] S_XBRE  = 5'd22;
	localparam logic [4:0] S_RBRL  = 5'd21;
	localparam logic [4:0] S_XBINT = 5'd17;
	localparam logic [4:0] S_RBINT = 5'd16;

	localparam logic [31:0] LOAD_MASK = (32'd1 << B_LDCTRL) | (32'd1 << B_LDIR) |
		(32'd1 << B_LRDR) | (32'd1 << B_LXDR);
	localparam logic [31:0] FLAG_MASK = LOAD_MASK | (32'd1 << B_BRKON);

	localparam int HOLD_CYCLES = 60;

	// request waiting to be offered, with pacing marks
	typedef struct packed {
		item_t it;
		logic  drain;   // hold this one back until every reply is in
		logic  choke;   // result side holds off once this one goes out
	} backlog_t;

	logic clk;
	logic arst_n;

	bar_req_if req_ch ();
	bar_rsp_if rsp_ch ();

	bit_addressed_uart_regs dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor state. Control, interval and rate registers never reach
	// an output, so only the load-flag walk through them is tracked; the
	// transmit data register is kept since its low byte is sent.
	// ------------------------------------------------------------------
	logic [31:0]      w_bits;
	logic [31:0]      s_bits;
	logic [REG_W-1:0] txd_r;

	backlog_t req_backlog[$];
	result_t  reply_q[$];

	int   n_made   = 0;   // requests queued by the stimulus
	int   n_sent   = 0;   // requests taken by the block
	int   n_seen   = 0;   // replies taken from the block
	int   errors   = 0;
	int   hold_left = 0;
	logic choke_go = 1'b0;
	logic steady   = 1'b0;  // no random idling on either side while set

	// Line event: latch a waiting character, note transmitter ready, then
	// rebuild the flag and interrupt bits from scratch.
	function automatic logic line_event(item_t it);
		logic took;
		took = 1'b0;
		if (it.rx_ready && !s_bits[S_RBRL]) begin
			s_bits[S_RBRL] = 1'b1;
			s_bits[CHAR_W-1:0] = it.rx_char;
			took = 1'b1;
		end
		if (it.tx_ready)
			s_bits[S_XBRE] = 1'b1;
		s_bits[S_XBINT] = s_bits[S_XBRE] & w_bits[B_XBIENB];
		s_bits[S_RBINT] = s_bits[S_RBRL] & w_bits[B_RIENB];
		s_bits[S_FLAG]  = |(w_bits & FLAG_MASK);
		s_bits[S_INT]   = s_bits[S_XBINT] | s_bits[S_RBINT];
		return took;
	endfunction

	// Expected reply for one request; advances the predictor state.
	function automatic result_t uart_reply(item_t it);
		result_t r;
		r = '0;
		case (it.command)
			CMD_WRITE: begin
				// bit lands in the control word before anything acts on it
				w_bits[it.bit_addr] = it.bit_value;
				if (it.bit_addr == B_RESET) begin
					w_bits = LOAD_MASK;
					s_bits = '0;
				end
				if (it.bit_addr == B_RIENB)
					s_bits[S_RBRL] = 1'b0;
				if (it.bit_addr <= REG_LAST) begin
					// first set load flag picks the target register
					if (w_bits[B_LDCTRL]) begin
						if (it.bit_addr == CTRL_LAST)
							w_bits[B_LDCTRL] = 1'b0;
					end else if (w_bits[B_LDIR]) begin
						if (it.bit_addr == CTRL_LAST)
							w_bits[B_LDIR] = 1'b0;
					end else if (w_bits[B_LRDR]) begin
						if (it.bit_addr == RATE_LAST)
							w_bits[B_LRDR] = 1'b0;
					end else if (w_bits[B_LXDR]) begin
						if (it.bit_addr == RATE_LAST)
							w_bits[B_LXDR] = 1'b0;
					end else begin
						txd_r[it.bit_addr] = it.bit_value;
						// send bit goes in first, then the whole byte leaves
						if (it.bit_addr == SEND_BIT) begin
							r.tx_valid = 1'b1;
							r.tx_char = txd_r[CHAR_W-1:0];
							s_bits[S_XBRE] = 1'b0;
						end
					end
				end
				r.rx_taken = line_event(it);
			end
			CMD_READ: r.read_bit = s_bits[it.bit_addr];
			CMD_POLL: r.rx_taken = line_event(it);
			default: ;
		endcase
		r.irq = s_bits[S_INT];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus building
	// ------------------------------------------------------------------
	function automatic item_t mk(logic [1:0] cmd, logic [4:0] addr, logic val,
		logic rxr, logic [7:0] rxc, logic txr);
		item_t it;
		it.command   = cmd;
		it.bit_addr  = addr;
		it.bit_value = val;
		it.rx_ready  = rxr;
		it.rx_char   = rxc;
		it.tx_ready  = txr;
		return it;
	endfunction

	// request with random serial-line fields
	function automatic item_t line_item(logic [1:0] cmd, logic [4:0] addr, logic val);
		return mk(cmd, addr, val, 1'($urandom), 8'($urandom), 1'($urandom));
	endfunction

	task automatic queue_req(item_t it);
		backlog_t e;
		e.it    = it;
		e.drain = (n_made == 300);
		e.choke = (n_made == 500 || n_made == 820);
		req_backlog.push_back(e);
		n_made++;
	endtask

	task automatic wr(logic [4:0] addr, logic val);
		queue_req(line_item(CMD_WRITE, addr, val));
	endtask

	// walk one data register up to its closing bit, skipping a few
	task automatic load_run(logic [4:0] last);
		for (int b = 0; b <= last; b++)
			if (b == last || $urandom_range(4) != 0)
				wr(5'(b), 1'($urandom));
	endtask

	task automatic send_char(logic [7:0] c);
		for (int b = 0; b < SEND_BIT; b++)
			if ($urandom_range(3) != 0)
				wr(5'(b), c[b]);
		if ($urandom_range(3) == 0)
			wr(5'($urandom_range(8, 10)), 1'($urandom));
		wr(SEND_BIT, c[7]);
	endtask

	// Well-formed bring-up: optional reset, load the registers in order, set
	// the interrupt enables, then send characters with line polls and status reads.
	task automatic session();
		logic       shadow;
		logic [4:0] pick;
		int         chars;
		shadow = 1'b1;
		chars = $urandom_range(1, 5);
		if ($urandom_range(4) != 0)
			wr(B_RESET, 1'($urandom));
		load_run(CTRL_LAST);
		load_run(CTRL_LAST);
		// dropping the transmit load flag splits the two rates
		if ($urandom_range(2) == 0) begin
			wr(B_LXDR, 1'b0);
			shadow = 1'b0;
		end
		load_run(RATE_LAST);
		if (shadow)
			load_run(RATE_LAST);
		wr(B_RIENB, 1'($urandom_range(3) != 0));
		wr(B_XBIENB, 1'($urandom_range(3) != 0));
		if ($urandom_range(5) == 0)
			wr(B_BRKON, 1'($urandom));
		repeat (chars) begin
			send_char(8'($urandom));
			repeat ($urandom_range(0, 3))
				queue_req(line_item(CMD_POLL, 5'($urandom), 1'($urandom)));
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(7))
					0: pick = S_INT;
					1: pick = S_FLAG;
					2: pick = S_XBRE;
					3: pick = S_RBRL;
					4: pick = S_XBINT;
					5: pick = S_RBINT;
					6: pick = 5'($urandom_range(CHAR_W - 1));
					default: pick = 5'($urandom);
				endcase
				queue_req(line_item(CMD_READ, pick, 1'($urandom)));
			end
			// release the held character so a new one can latch
			if ($urandom_range(2) == 0)
				wr(B_RIENB, 1'b1);
		end
	endtask

	// ------------------------------------------------------------------
	// Request driver: offers the backlog with random gaps, predicts each
	// request as it is taken.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		backlog_t nxt;
		logic     offer;
		logic     choke_now;
		offer = 1'b0;
		choke_now = 1'b0;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				reply_q.push_back(uart_reply(req_ch.data));
				n_sent <= n_sent + 1;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (req_backlog.size() != 0 && (steady || $urandom_range(99) >= 11)) begin
					nxt = req_backlog[0];
					// a drain mark waits for an empty pipe and all replies back
					if (!nxt.drain || (!req_ch.valid && n_seen == n_sent))
						offer = 1'b1;
				end
				if (offer) begin
					nxt = req_backlog.pop_front();
					req_ch.data <= nxt.it;
					choke_now = nxt.choke;
				end
				req_ch.valid <= offer;
			end
			steady <= (n_sent >= 600 && n_sent < 750);
		end
		choke_go <= choke_now;
	end

	// long result-side hold-off, counted here
	always @(posedge clk) begin
		if (choke_go)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	task automatic log_mismatch(string what, result_t want, result_t got);
		errors++;
		if (errors <= 10)
			$display("%0t %s: want rd=%b txv=%b txc=%h taken=%b irq=%b, got rd=%b txv=%b txc=%h taken=%b irq=%b",
				$realtime, what, want.read_bit, want.tx_valid, want.tx_char,
				want.rx_taken, want.irq, got.read_bit, got.tx_valid, got.tx_char,
				got.rx_taken, got.irq);
	endtask

	// ------------------------------------------------------------------
	// Reply monitor: random stalls plus the hold-off window
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.data;
				if (reply_q.size() == 0) begin
					log_mismatch("unexpected reply", '0, got);
				end else begin
					want = reply_q.pop_front();
					if (got.read_bit !== want.read_bit || got.tx_valid !== want.tx_valid ||
						got.tx_char !== want.tx_char || got.rx_taken !== want.rx_taken ||
						got.irq !== want.irq)
						log_mismatch("reply mismatch", want, got);
				end
				n_seen <= n_seen + 1;
			end
			rsp_ch.ready <= (hold_left == 0) && (steady || $urandom_range(99) >= 11);
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		w_bits = LOAD_MASK;
		s_bits = '0;
		txd_r = '0;

		// directed: status at reset, latching, enables, flags, direct load
		// flag clears, a send, the rate shadow, and the block reset
		queue_req(mk(CMD_READ, S_INT, 1'b0, 1'b0, 8'h00, 1'b0));
		queue_req(mk(CMD_POLL, 5'd0, 1'b0, 1'b1, 8'hFF, 1'b1));
		queue_req(mk(CMD_READ, S_RBRL, 1'b0, 1'b0, 8'h00, 1'b0));
		queue_req(mk(CMD_READ, 5'd7, 1'b0, 1'b0, 8'h00, 1'b0));
		queue_req(mk(CMD_READ, S_XBRE, 1'b1, 1'b0, 8'h00, 1'b0));
		// receive-enable write clears receive-full, then a new char latches
		queue_req(mk(CMD_WRITE, B_RIENB, 1'b1, 1'b1, 8'h00, 1'b0));
		// char held: a second one is not taken
		queue_req(mk(CMD_POLL, 5'd31, 1'b1, 1'b1, 8'hA5, 1'b0));
		queue_req(mk(CMD_WRITE, B_XBIENB, 1'b1, 1'b0, 8'h00, 1'b1));
		queue_req(mk(CMD_READ, S_FLAG, 1'b0, 1'b0, 8'h00, 1'b0));
		queue_req(mk(CMD_READ, S_XBINT, 1'b0, 1'b0, 8'h00, 1'b0));
		queue_req(mk(CMD_WRITE, B_LDCTRL, 1'b0, 1'b0, 8'h00, 1'b0));
		queue_req(mk(CMD_WRITE, B_LDIR, 1'b0, 1'b0, 8'h00, 1'b0));
		queue_req(mk(CMD_WRITE, B_LRDR, 1'b0, 1'b0, 8'h00, 1'b0));
		// bit 11 with every load flag gone falls into transmit data
		queue_req(mk(CMD_WRITE, B_LXDR, 1'b0, 1'b0, 8'h00, 1'b0));
		queue_req(mk(CMD_WRITE, B_BRKON, 1'b1, 1'b0, 8'h00, 1'b0));
		queue_req(mk(CMD_READ, S_FLAG, 1'b0, 1'b0, 8'h00, 1'b0));
		queue_req(mk(CMD_WRITE, B_BRKON, 1'b0, 1'b0, 8'h00, 1'b0));
		queue_req(mk(CMD_WRITE, 5'd0, 1'b1, 1'b0, 8'h00, 1'b0));
		// send bit: 0x81 leaves, transmitter goes busy
		queue_req(mk(CMD_WRITE, SEND_BIT, 1'b1, 1'b0, 8'h00, 1'b0));
		// bit 11 sets the transmit load flag before it is routed
		queue_req(mk(CMD_WRITE, B_LXDR, 1'b1, 1'b0, 8'h00, 1'b1));
		queue_req(mk(CMD_WRITE, RATE_LAST, 1'b1, 1'b1, 8'h5A, 1'b0));
		// block reset works whatever the written value
		queue_req(mk(CMD_WRITE, B_RESET, 1'b0, 1'b0, 8'h00, 1'b0));
		queue_req(mk(CMD_WRITE, B_RESET, 1'b1, 1'b1, 8'hFF, 1'b1));
		queue_req(mk(CMD_READ, S_INT, 1'b1, 1'b1, 8'hFF, 1'b1));
		queue_req(mk(CMD_POLL, 5'd31, 1'b1, 1'b1, 8'hFF, 1'b1));

		// random: mostly bring-up sessions, some raw noise
		while (n_made < 975) begin
			if ($urandom_range(9) < 6)
				session();
			else
				repeat ($urandom_range(5, 20))
					queue_req(line_item(2'($urandom_range(2)), 5'($urandom), 1'($urandom)));
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		@(posedge clk);
		while (req_backlog.size() != 0 || req_ch.valid || n_seen != n_sent)
			@(posedge clk);
		// two-stage pipe; a few more edges catch any stray reply
		repeat (8) @(posedge clk);
		errors += reply_q.size();

		if (errors == 0)
			$display("tb_bit_addressed_uart_regs: clean");
		else
			$display("tb_bit_addressed_uart_regs: errors");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("tb_bit_addressed_uart_regs: errors");
		$finish;
	end

endmodule
